/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("qrs assertion failed");
`define QRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrs assertion failed");
`else
`define QRS_ASSERT(lbl, clk, rst_n, prop)
`define QRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/qrs_pkg.sv */
// shared constants and types of the quadratic root solver
package qrs_pkg;
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [1:0] ST_NO_REAL   = 2'd0;
    localparam logic [1:0] ST_DISTINCT  = 2'd1;
    localparam logic [1:0] ST_REPEATED  = 2'd2;
    localparam logic [1:0] ST_A_ZERO    = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
    } qrs_ctl_t;
endpackage

/* hw/rtl/quadratic_root_solver.sv */
// path: a word passes the input register, stages 1 and 2, the square root chain of
// WORD_BITS+1 cells, stages 3 to 5, the divider chains of WORD_BITS cells, stage 6
// and the output register. throughput: one word per cycle unless stalled, set by the
// fully pipelined cell chains; a two-entry output stage keeps s_tready registered.
// reset: aresetn synchronous active low clears all valid bits, those of the output stage too.
`include "assert_macros.svh"
module quadratic_root_solver #(
    parameter int WORD_BITS = qrs_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = qrs_pkg::DEF_FRAC_BITS,
    localparam int IN_W  = ((3 * WORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * WORD_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // coef_a, coef_b, coef_c
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // root_plus, root_minus
    output logic [2:0]       m_tuser    // root_status, saturated
);
    import qrs_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DW   = 2 * W + 2;
    localparam int SQ   = W + 1;
    localparam int SW   = W + 1;
    localparam int RW   = W + 4;
    localparam int NBW  = W + F + 3;
    localparam int DVW  = W + 1;
    localparam int HIW  = F + 3;
    localparam int CMPW = (HIW > DVW) ? HIW : DVW;

    logic en;

    // stage 0: input registers
    logic         v0_reg;
    logic [W-1:0] a0_reg, b0_reg, c0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg <= s_tdata[W-1:0];
            b0_reg <= s_tdata[2*W-1:W];
            c0_reg <= s_tdata[3*W-1:2*W];
        end
    end

    // stage 1: magnitude products b*b and a*c
    logic [W-1:0]   abs_a0, abs_b0, abs_c0;
    logic           v1_reg, sdiff1_reg;
    logic [W-1:0]   a1_reg, b1_reg;
    logic [2*W-1:0] bb1_reg, ac1_reg;

    always_comb begin
        abs_a0 = a0_reg[W-1] ? (~a0_reg + 1'b1) : a0_reg;
        abs_b0 = b0_reg[W-1] ? (~b0_reg + 1'b1) : b0_reg;
        abs_c0 = c0_reg[W-1] ? (~c0_reg + 1'b1) : c0_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bb1_reg    <= {{W{1'b0}}, abs_b0} * {{W{1'b0}}, abs_b0};
            ac1_reg    <= {{W{1'b0}}, abs_a0} * {{W{1'b0}}, abs_c0};
            sdiff1_reg <= a0_reg[W-1] ^ c0_reg[W-1];
            a1_reg     <= a0_reg;
            b1_reg     <= b0_reg;
        end
    end

    // stage 2: discriminant and status
    logic [DW-1:0] bbx, ac4, d_sum, d_dif, d_val;
    logic [1:0]    st_next;
    qrs_ctl_t      ctl2_reg;
    logic [DW-1:0] d2_reg;
    logic [W-1:0]  a2_reg, b2_reg;

    always_comb begin
        bbx   = {2'b00, bb1_reg};
        ac4   = {ac1_reg, 2'b00};
        d_sum = bbx + ac4;
        d_dif = bbx - ac4;
        d_val = sdiff1_reg ? d_sum : d_dif;
        if (a1_reg == '0) begin
            st_next = ST_A_ZERO;
        end else if (!sdiff1_reg && (bbx < ac4)) begin
            st_next = ST_NO_REAL;
        end else if (d_val == '0) begin
            st_next = ST_REPEATED;
        end else begin
            st_next = ST_DISTINCT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl2_reg.valid <= 1'b0;
        end else if (en) begin
            ctl2_reg.valid <= v1_reg;
        end
        if (en) begin
            ctl2_reg.status <= st_next;
            d2_reg          <= d_val;
            a2_reg          <= a1_reg;
            b2_reg          <= b1_reg;
        end
    end

    // square root chain
    qrs_ctl_t         sq_ctl   [0:SQ];
    logic [RW-1:0]    sq_rem   [0:SQ];
    logic [SW-1:0]    sq_root  [0:SQ];
    logic [DW-1:0]    sq_dbits [0:SQ];
    logic [2*W-1:0]   sq_side  [0:SQ];

    assign sq_ctl[0]   = ctl2_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_dbits[0] = d2_reg;
    assign sq_side[0]  = {a2_reg, b2_reg};

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        qrs_sqrt_cell #(
            .RW(RW), .SW(SW), .DW(DW), .SIDE_W(2 * W)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .ctl_i(sq_ctl[k]), .rem_i(sq_rem[k]), .root_i(sq_root[k]),
            .dbits_i(sq_dbits[k]), .side_i(sq_side[k]),
            .ctl_o(sq_ctl[k+1]), .rem_o(sq_rem[k+1]), .root_o(sq_root[k+1]),
            .dbits_o(sq_dbits[k+1]), .side_o(sq_side[k+1])
        );
    end

    // stage 3: numerators -b + s and -b - s
    logic [W-1:0]  sq_a, sq_b;
    logic [W+2:0]  bx, sx;
    qrs_ctl_t      ctl3_reg;
    logic [W-1:0]  a3_reg;
    logic [W+2:0]  nump3_reg, numm3_reg;

    always_comb begin
        sq_a = sq_side[SQ][2*W-1:W];
        sq_b = sq_side[SQ][W-1:0];
        bx   = {{3{sq_b[W-1]}}, sq_b};
        sx   = {2'b00, sq_root[SQ]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl3_reg.valid <= 1'b0;
        end else if (en) begin
            ctl3_reg.valid <= sq_ctl[SQ].valid;
        end
        if (en) begin
            ctl3_reg.status <= sq_ctl[SQ].status;
            a3_reg          <= sq_a;
            nump3_reg       <= sx - bx;
            numm3_reg       <= '0 - sx - bx;
        end
    end

    // stage 4: rounded dividends, divisor 2|a| and signs
    logic [W-1:0]   abs_a3;
    logic [W+2:0]   absp3, absm3;
    qrs_ctl_t       ctl4_reg;
    logic [NBW-1:0] np4_reg, nm4_reg;
    logic [DVW-1:0] dvs4_reg;
    logic           negp4_reg, negm4_reg;

    always_comb begin
        abs_a3 = a3_reg[W-1] ? (~a3_reg + 1'b1) : a3_reg;
        absp3  = nump3_reg[W+2] ? (~nump3_reg + 1'b1) : nump3_reg;
        absm3  = numm3_reg[W+2] ? (~numm3_reg + 1'b1) : numm3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl4_reg.valid <= 1'b0;
        end else if (en) begin
            ctl4_reg.valid <= ctl3_reg.valid;
        end
        if (en) begin
            ctl4_reg.status <= ctl3_reg.status;
            np4_reg   <= {1'b0, absp3[W+1:0], {F{1'b0}}} + NBW'(abs_a3);
            nm4_reg   <= {1'b0, absm3[W+1:0], {F{1'b0}}} + NBW'(abs_a3);
            dvs4_reg  <= {abs_a3, 1'b0};
            negp4_reg <= nump3_reg[W+2] ^ a3_reg[W-1];
            negm4_reg <= numm3_reg[W+2] ^ a3_reg[W-1];
        end
    end

    // stage 5: quotient overflow check and divider start
    logic [HIW-1:0] hip4, him4;
    logic           ovfp_next, ovfm_next;
    qrs_ctl_t       ctl5_reg;
    logic [DVW-1:0] remp5_reg, remm5_reg, dvs5_reg;
    logic [W-1:0]   nlp5_reg, nlm5_reg;
    logic [1:0]     sidep5_reg, sidem5_reg;

    always_comb begin
        hip4      = np4_reg[NBW-1:W];
        him4      = nm4_reg[NBW-1:W];
        ovfp_next = CMPW'(hip4) >= CMPW'(dvs4_reg);
        ovfm_next = CMPW'(him4) >= CMPW'(dvs4_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl5_reg.valid <= 1'b0;
        end else if (en) begin
            ctl5_reg.valid <= ctl4_reg.valid;
        end
        if (en) begin
            ctl5_reg.status <= ctl4_reg.status;
            remp5_reg  <= DVW'(hip4);
            remm5_reg  <= DVW'(him4);
            dvs5_reg   <= dvs4_reg;
            nlp5_reg   <= np4_reg[W-1:0];
            nlm5_reg   <= nm4_reg[W-1:0];
            sidep5_reg <= {negp4_reg, ovfp_next};
            sidem5_reg <= {negm4_reg, ovfm_next};
        end
    end

    // divider chains, one lane per root
    qrs_ctl_t       dp_ctl [0:W], dm_ctl [0:W];
    logic [DVW-1:0] dp_rem [0:W], dm_rem [0:W];
    logic [DVW-1:0] dp_dvs [0:W], dm_dvs [0:W];
    logic [W-1:0]   dp_quo [0:W], dm_quo [0:W];
    logic [W-1:0]   dp_nb  [0:W], dm_nb  [0:W];
    logic [1:0]     dp_sd  [0:W], dm_sd  [0:W];

    assign dp_ctl[0] = ctl5_reg;
    assign dm_ctl[0] = ctl5_reg;
    assign dp_rem[0] = remp5_reg;
    assign dm_rem[0] = remm5_reg;
    assign dp_dvs[0] = dvs5_reg;
    assign dm_dvs[0] = dvs5_reg;
    assign dp_quo[0] = '0;
    assign dm_quo[0] = '0;
    assign dp_nb[0]  = nlp5_reg;
    assign dm_nb[0]  = nlm5_reg;
    assign dp_sd[0]  = sidep5_reg;
    assign dm_sd[0]  = sidem5_reg;

    for (genvar k = 0; k < W; k++) begin : g_div
        qrs_div_cell #(
            .DVW(DVW), .QW(W), .SIDE_W(2)
        ) u_plus (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .ctl_i(dp_ctl[k]), .rem_i(dp_rem[k]), .dvs_i(dp_dvs[k]),
            .quo_i(dp_quo[k]), .nbits_i(dp_nb[k]), .side_i(dp_sd[k]),
            .ctl_o(dp_ctl[k+1]), .rem_o(dp_rem[k+1]), .dvs_o(dp_dvs[k+1]),
            .quo_o(dp_quo[k+1]), .nbits_o(dp_nb[k+1]), .side_o(dp_sd[k+1])
        );
        qrs_div_cell #(
            .DVW(DVW), .QW(W), .SIDE_W(2)
        ) u_minus (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .ctl_i(dm_ctl[k]), .rem_i(dm_rem[k]), .dvs_i(dm_dvs[k]),
            .quo_i(dm_quo[k]), .nbits_i(dm_nb[k]), .side_i(dm_sd[k]),
            .ctl_o(dm_ctl[k+1]), .rem_o(dm_rem[k+1]), .dvs_o(dm_dvs[k+1]),
            .quo_o(dm_quo[k+1]), .nbits_o(dm_nb[k+1]), .side_o(dm_sd[k+1])
        );
    end

    // stage 6: saturation, sign and status masking
    localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};

    logic [W-1:0] lim_p, lim_m, mag_p, mag_m, res_p, res_m;
    logic         clamp_p, clamp_m, is_real, fin_valid;
    logic [1:0]   fin_status;
    logic         pv_reg;
    logic [W-1:0] prp_reg, prm_reg;
    logic [1:0]   pst_reg;
    logic         psat_reg;

    always_comb begin
        fin_valid  = dp_ctl[W].valid & dm_ctl[W].valid;
        fin_status = dp_ctl[W].status;
        lim_p      = dp_sd[W][1] ? NEG_LIM : POS_LIM;
        lim_m      = dm_sd[W][1] ? NEG_LIM : POS_LIM;
        clamp_p    = dp_sd[W][0] || (dp_quo[W] > lim_p);
        clamp_m    = dm_sd[W][0] || (dm_quo[W] > lim_m);
        mag_p      = clamp_p ? lim_p : dp_quo[W];
        mag_m      = clamp_m ? lim_m : dm_quo[W];
        res_p      = dp_sd[W][1] ? (~mag_p + 1'b1) : mag_p;
        res_m      = dm_sd[W][1] ? (~mag_m + 1'b1) : mag_m;
        is_real    = (fin_status == ST_DISTINCT) || (fin_status == ST_REPEATED);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= fin_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prp_reg  <= is_real ? res_p : '0;
            prm_reg  <= is_real ? res_m : '0;
            pst_reg  <= fin_status;
            psat_reg <= is_real && (clamp_p || clamp_m);
        end
    end

    // output word register with one skid entry behind it
    logic         out_valid_reg, skid_valid_reg;
    logic [W-1:0] out_rp_reg, out_rm_reg, skid_rp_reg, skid_rm_reg;
    logic [1:0]   out_st_reg, skid_st_reg;
    logic         out_sat_reg, skid_sat_reg;
    logic         out_load;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign out_load = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_load) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= pv_reg;
            end
        end else if (pv_reg && en) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (skid_valid_reg) begin
                out_rp_reg  <= skid_rp_reg;
                out_rm_reg  <= skid_rm_reg;
                out_st_reg  <= skid_st_reg;
                out_sat_reg <= skid_sat_reg;
            end else begin
                out_rp_reg  <= prp_reg;
                out_rm_reg  <= prm_reg;
                out_st_reg  <= pst_reg;
                out_sat_reg <= psat_reg;
            end
        end else if (en) begin
            skid_rp_reg  <= prp_reg;
            skid_rm_reg  <= prm_reg;
            skid_st_reg  <= pst_reg;
            skid_sat_reg <= psat_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({out_rm_reg, out_rp_reg});
    assign m_tuser  = {out_sat_reg, out_st_reg};

    // checks
    logic out_no_root, out_zeroed;

    assign out_no_root = out_valid_reg &&
                         !(out_st_reg == ST_DISTINCT || out_st_reg == ST_REPEATED);
    assign out_zeroed  = out_rp_reg == '0 && out_rm_reg == '0 && !out_sat_reg;

    `QRS_ASSERT(a_skid_behind_out, aclk, aresetn, !skid_valid_reg || out_valid_reg)
    `QRS_ASSERT_NEXT(a_skid_holds, aclk, aresetn, skid_valid_reg && !m_tready, skid_valid_reg)
    `QRS_ASSERT(a_no_root_zero, aclk, aresetn, !out_no_root || out_zeroed)
endmodule

/* hw/rtl/qrs_sqrt_cell.sv */
// one cell of the digit-by-digit square root chain, two radicand bits per cell
module qrs_sqrt_cell #(
    parameter int RW = 36,
    parameter int SW = 33,
    parameter int DW = 66,
    parameter int SIDE_W = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  qrs_pkg::qrs_ctl_t  ctl_i,
    input  logic [RW-1:0]      rem_i,
    input  logic [SW-1:0]      root_i,
    input  logic [DW-1:0]      dbits_i,
    input  logic [SIDE_W-1:0]  side_i,
    output qrs_pkg::qrs_ctl_t  ctl_o,
    output logic [RW-1:0]      rem_o,
    output logic [SW-1:0]      root_o,
    output logic [DW-1:0]      dbits_o,
    output logic [SIDE_W-1:0]  side_o
);
    import qrs_pkg::*;

    logic              valid_reg;
    logic [1:0]        status_reg;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [SW-1:0]     root_reg, root_next;
    logic [DW-1:0]     dbits_reg, dbits_next;
    logic [SIDE_W-1:0] side_reg;
    logic [RW-1:0]     rem_sh, trial;
    logic              ge;

    // trial subtract of 4*root+1 from the shifted remainder
    always_comb begin
        rem_sh     = {rem_i[RW-3:0], dbits_i[DW-1:DW-2]};
        trial      = RW'({root_i, 2'b01});
        ge         = rem_sh >= trial;
        rem_next   = ge ? (rem_sh - trial) : rem_sh;
        root_next  = {root_i[SW-2:0], ge};
        dbits_next = {dbits_i[DW-3:0], 2'b00};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_i.valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            status_reg <= ctl_i.status;
            rem_reg    <= rem_next;
            root_reg   <= root_next;
            dbits_reg  <= dbits_next;
            side_reg   <= side_i;
        end
    end

    always_comb begin
        ctl_o.valid  = valid_reg;
        ctl_o.status = status_reg;
    end
    assign rem_o   = rem_reg;
    assign root_o  = root_reg;
    assign dbits_o = dbits_reg;
    assign side_o  = side_reg;
endmodule

/* hw/rtl/qrs_div_cell.sv */
// one cell of the restoring divider chain, one quotient bit per cell
module qrs_div_cell #(
    parameter int DVW = 33,
    parameter int QW = 32,
    parameter int SIDE_W = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  qrs_pkg::qrs_ctl_t  ctl_i,
    input  logic [DVW-1:0]     rem_i,
    input  logic [DVW-1:0]     dvs_i,
    input  logic [QW-1:0]      quo_i,
    input  logic [QW-1:0]      nbits_i,
    input  logic [SIDE_W-1:0]  side_i,
    output qrs_pkg::qrs_ctl_t  ctl_o,
    output logic [DVW-1:0]     rem_o,
    output logic [DVW-1:0]     dvs_o,
    output logic [QW-1:0]      quo_o,
    output logic [QW-1:0]      nbits_o,
    output logic [SIDE_W-1:0]  side_o
);
    import qrs_pkg::*;

    logic              valid_reg;
    logic [1:0]        status_reg;
    logic [DVW-1:0]    rem_reg, rem_next;
    logic [DVW-1:0]    dvs_reg;
    logic [QW-1:0]     quo_reg, quo_next;
    logic [QW-1:0]     nbits_reg, nbits_next;
    logic [SIDE_W-1:0] side_reg;
    logic [DVW:0]      rem_sh, rem_sub;
    logic              ge;

    // shift in the next numerator bit and try the divisor
    always_comb begin
        rem_sh     = {rem_i, nbits_i[QW-1]};
        ge         = rem_sh >= {1'b0, dvs_i};
        rem_sub    = rem_sh - {1'b0, dvs_i};
        rem_next   = ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
        quo_next   = {quo_i[QW-2:0], ge};
        nbits_next = {nbits_i[QW-2:0], 1'b0};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_i.valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            status_reg <= ctl_i.status;
            rem_reg    <= rem_next;
            dvs_reg    <= dvs_i;
            quo_reg    <= quo_next;
            nbits_reg  <= nbits_next;
            side_reg   <= side_i;
        end
    end

    always_comb begin
        ctl_o.valid  = valid_reg;
        ctl_o.status = status_reg;
    end
    assign rem_o   = rem_reg;
    assign dvs_o   = dvs_reg;
    assign quo_o   = quo_reg;
    assign nbits_o = nbits_reg;
    assign side_o  = side_reg;
endmodule
